FILE: rtl/m64ieu_pkg.sv
// Shared types and helpers for the 64-bit integer execute unit.
// Holds the opcode encoding, the execute result bundle and sign-extension helpers.
// No dependencies.
package m64ieu_pkg;

    localparam int unsigned XLEN     = 64;
    localparam int unsigned REG_CNT  = 32;
    localparam int unsigned REG_AW   = 5;
    localparam int unsigned OP_W     = 6;
    localparam int unsigned IMM_W    = 16;
    localparam int unsigned IN_DW    = 40;
    localparam int unsigned OUT_DW   = 200;

    // Dense opcode numbering of the decoded instruction stream.
    typedef enum logic [OP_W-1:0] {
        OP_NOP    = 6'd0,
        OP_SLL    = 6'd1,
        OP_SRL    = 6'd2,
        OP_SRA    = 6'd3,
        OP_DSLL   = 6'd4,
        OP_DSRL   = 6'd5,
        OP_DSRA   = 6'd6,
        OP_DSLL32 = 6'd7,
        OP_DSRL32 = 6'd8,
        OP_DSRA32 = 6'd9,
        OP_SLLV   = 6'd10,
        OP_SRLV   = 6'd11,
        OP_SRAV   = 6'd12,
        OP_DSLLV  = 6'd13,
        OP_DSRLV  = 6'd14,
        OP_DSRAV  = 6'd15,
        OP_ADD    = 6'd16,
        OP_ADDU   = 6'd17,
        OP_SUB    = 6'd18,
        OP_SUBU   = 6'd19,
        OP_AND    = 6'd20,
        OP_OR     = 6'd21,
        OP_XOR    = 6'd22,
        OP_NOR    = 6'd23,
        OP_SLT    = 6'd24,
        OP_SLTU   = 6'd25,
        OP_DADD   = 6'd26,
        OP_DADDU  = 6'd27,
        OP_DSUB   = 6'd28,
        OP_DSUBU  = 6'd29,
        OP_ADDI   = 6'd30,
        OP_ADDIU  = 6'd31,
        OP_SLTI   = 6'd32,
        OP_SLTIU  = 6'd33,
        OP_ANDI   = 6'd34,
        OP_ORI    = 6'd35,
        OP_XORI   = 6'd36,
        OP_LUI    = 6'd37,
        OP_DADDI  = 6'd38,
        OP_DADDIU = 6'd39,
        OP_MFHI   = 6'd40,
        OP_MFLO   = 6'd41,
        OP_MTHI   = 6'd42,
        OP_MTLO   = 6'd43,
        OP_MULT   = 6'd44,
        OP_MULTU  = 6'd45
    } t_op;

    // What one instruction does to the architectural state.
    typedef struct packed {
        logic              gpr_we;
        logic [REG_AW-1:0] gpr_idx;
        logic [XLEN-1:0]   gpr_val;
        logic              hi_we;
        logic [XLEN-1:0]   hi_val;
        logic              lo_we;
        logic [XLEN-1:0]   lo_val;
        logic              bad_op;
    } t_exec_res;

    // Sign-extend the low word of a 64-bit value.
    function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    // Sign-extend a 16-bit immediate.
    function automatic logic [XLEN-1:0] sext16(input logic [IMM_W-1:0] v);
        return {{(XLEN-IMM_W){v[IMM_W-1]}}, v};
    endfunction

endpackage

FILE: rtl/m64ieu_regfile.sv
// General register file of the execute unit: 32 x 64-bit memory, two read ports.
// Read data is registered; a write-valid bit per entry makes unwritten entries read zero,
// and the last write is forwarded to a read issued on the same edge. Uses m64ieu_pkg.
module m64ieu_regfile (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_rd_en,
    input  logic [m64ieu_pkg::REG_AW-1:0]    i_rd_addr_a,
    input  logic [m64ieu_pkg::REG_AW-1:0]    i_rd_addr_b,
    input  logic                             i_wr_en,
    input  logic [m64ieu_pkg::REG_AW-1:0]    i_wr_addr,
    input  logic [m64ieu_pkg::XLEN-1:0]      i_wr_data,
    output logic [m64ieu_pkg::XLEN-1:0]      o_rd_data_a,
    output logic [m64ieu_pkg::XLEN-1:0]      o_rd_data_b
);
    import m64ieu_pkg::*;

    logic [XLEN-1:0]    r_mem [REG_CNT];
    logic [REG_CNT-1:0] r_valid;
    logic [XLEN-1:0]    r_rd_a;
    logic [XLEN-1:0]    r_rd_b;
    logic               r_vld_a;
    logic               r_vld_b;
    logic [REG_AW-1:0]  r_addr_a;
    logic [REG_AW-1:0]  r_addr_b;
    logic               r_fwd_en;
    logic [REG_AW-1:0]  r_fwd_addr;
    logic [XLEN-1:0]    r_fwd_data;

    // Memory write and registered reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a   <= r_mem[i_rd_addr_a];
            r_rd_b   <= r_mem[i_rd_addr_b];
            r_addr_a <= i_rd_addr_a;
            r_addr_b <= i_rd_addr_b;
        end
        if (i_wr_en) begin
            r_fwd_addr <= i_wr_addr;
            r_fwd_data <= i_wr_data;
        end
    end

    // Per-entry written flags and the forwarding flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_vld_a  <= 1'b0;
            r_vld_b  <= 1'b0;
            r_fwd_en <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
                r_fwd_en           <= 1'b1;
            end
            if (i_rd_en) begin
                r_vld_a <= r_valid[i_rd_addr_a];
                r_vld_b <= r_valid[i_rd_addr_b];
            end
        end
    end

    // The most recent write wins over the memory copy, which may predate it.
    always_comb begin
        if (r_fwd_en && (r_fwd_addr == r_addr_a)) begin
            o_rd_data_a = r_fwd_data;
        end else begin
            o_rd_data_a = r_vld_a ? r_rd_a : '0;
        end
        if (r_fwd_en && (r_fwd_addr == r_addr_b)) begin
            o_rd_data_b = r_fwd_data;
        end else begin
            o_rd_data_b = r_vld_b ? r_rd_b : '0;
        end
    end

endmodule

FILE: rtl/m64ieu_alu.sv
// Combinational execute logic: shifts, add/sub, logic, compares, HI/LO moves, multiply.
// Produces the state update of one instruction as a t_exec_res bundle. Uses m64ieu_pkg.
module m64ieu_alu (
    input  logic [m64ieu_pkg::OP_W-1:0]   i_op,
    input  logic [m64ieu_pkg::XLEN-1:0]   i_rs,
    input  logic [m64ieu_pkg::XLEN-1:0]   i_rt,
    input  logic [m64ieu_pkg::REG_AW-1:0] i_rt_idx,
    input  logic [m64ieu_pkg::REG_AW-1:0] i_rd_idx,
    input  logic [m64ieu_pkg::IMM_W-1:0]  i_imm,
    input  logic [m64ieu_pkg::XLEN-1:0]   i_hi,
    input  logic [m64ieu_pkg::XLEN-1:0]   i_lo,
    output m64ieu_pkg::t_exec_res         o_res
);
    import m64ieu_pkg::*;

    logic [4:0]         sa;
    logic [5:0]         sa32;
    logic [4:0]         vsa32;
    logic [5:0]         vsa64;
    logic [XLEN-1:0]    rt_lo;
    logic [XLEN-1:0]    rt_sx;
    logic [XLEN-1:0]    simm;
    logic [XLEN-1:0]    zimm;
    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    logic [65:0]        mul_p;
    logic               mul_signed;
    logic               we;
    logic [REG_AW-1:0]  widx;
    logic [XLEN-1:0]    val;

    assign sa    = i_imm[4:0];
    assign sa32  = {1'b1, sa};
    assign vsa32 = i_rs[4:0];
    assign vsa64 = i_rs[5:0];
    assign rt_lo = {32'b0, i_rt[31:0]};
    assign rt_sx = sext32(i_rt);
    assign simm  = sext16(i_imm);
    assign zimm  = {{(XLEN-IMM_W){1'b0}}, i_imm};

    // One 33x33 signed multiplier serves both the signed and unsigned word multiply.
    assign mul_signed = (t_op'(i_op) == OP_MULT);
    assign mul_a      = {mul_signed & i_rs[31], i_rs[31:0]};
    assign mul_b      = {mul_signed & i_rt[31], i_rt[31:0]};
    assign mul_p      = 66'($signed(mul_a) * $signed(mul_b));

    // Opcode decode and result selection.
    always_comb begin
        we           = 1'b0;
        widx         = i_rd_idx;
        val          = '0;
        o_res.hi_we  = 1'b0;
        o_res.hi_val = i_rs;
        o_res.lo_we  = 1'b0;
        o_res.lo_val = i_rs;
        o_res.bad_op = 1'b0;
        unique case (t_op'(i_op)) inside
            OP_NOP: ;
            OP_SLL:    begin we = 1'b1; val = sext32(rt_lo << sa); end
            OP_SRL:    begin we = 1'b1; val = sext32(rt_lo >> sa); end
            OP_SRA:    begin we = 1'b1; val = $signed(rt_sx) >>> sa; end
            OP_DSLL:   begin we = 1'b1; val = i_rt << sa; end
            OP_DSRL:   begin we = 1'b1; val = i_rt >> sa; end
            OP_DSRA:   begin we = 1'b1; val = $signed(i_rt) >>> sa; end
            OP_DSLL32: begin we = 1'b1; val = i_rt << sa32; end
            OP_DSRL32: begin we = 1'b1; val = i_rt >> sa32; end
            OP_DSRA32: begin we = 1'b1; val = $signed(i_rt) >>> sa32; end
            OP_SLLV:   begin we = 1'b1; val = sext32(rt_lo << vsa32); end
            OP_SRLV:   begin we = 1'b1; val = sext32(rt_lo >> vsa32); end
            OP_SRAV:   begin we = 1'b1; val = $signed(rt_sx) >>> vsa32; end
            OP_DSLLV:  begin we = 1'b1; val = i_rt << vsa64; end
            OP_DSRLV:  begin we = 1'b1; val = i_rt >> vsa64; end
            OP_DSRAV:  begin we = 1'b1; val = $signed(i_rt) >>> vsa64; end
            OP_ADD, OP_ADDU: begin
                we  = 1'b1;
                val = sext32(i_rs + i_rt);
            end
            OP_SUB, OP_SUBU: begin
                we  = 1'b1;
                val = sext32(i_rs - i_rt);
            end
            OP_AND:    begin we = 1'b1; val = i_rs & i_rt; end
            OP_OR:     begin we = 1'b1; val = i_rs | i_rt; end
            OP_XOR:    begin we = 1'b1; val = i_rs ^ i_rt; end
            OP_NOR:    begin we = 1'b1; val = ~(i_rs | i_rt); end
            OP_SLT: begin
                we  = 1'b1;
                val = {63'b0, $signed(i_rs) < $signed(i_rt)};
            end
            OP_SLTU:   begin we = 1'b1; val = {63'b0, i_rs < i_rt}; end
            OP_DADD, OP_DADDU: begin
                we  = 1'b1;
                val = i_rs + i_rt;
            end
            OP_DSUB, OP_DSUBU: begin
                we  = 1'b1;
                val = i_rs - i_rt;
            end
            OP_ADDI, OP_ADDIU: begin
                we   = 1'b1;
                widx = i_rt_idx;
                val  = sext32(i_rs + simm);
            end
            OP_SLTI: begin
                we   = 1'b1;
                widx = i_rt_idx;
                val  = {63'b0, $signed(i_rs) < $signed(simm)};
            end
            OP_SLTIU: begin
                we   = 1'b1;
                widx = i_rt_idx;
                val  = {63'b0, i_rs < simm};
            end
            OP_ANDI:   begin we = 1'b1; widx = i_rt_idx; val = i_rs & zimm; end
            OP_ORI:    begin we = 1'b1; widx = i_rt_idx; val = i_rs | zimm; end
            OP_XORI:   begin we = 1'b1; widx = i_rt_idx; val = i_rs ^ zimm; end
            OP_LUI: begin
                we   = 1'b1;
                widx = i_rt_idx;
                val  = sext32({32'b0, i_imm, 16'b0});
            end
            OP_DADDI, OP_DADDIU: begin
                we   = 1'b1;
                widx = i_rt_idx;
                val  = i_rs + simm;
            end
            OP_MFHI:   begin we = 1'b1; val = i_hi; end
            OP_MFLO:   begin we = 1'b1; val = i_lo; end
            OP_MTHI:   o_res.hi_we = 1'b1;
            OP_MTLO:   o_res.lo_we = 1'b1;
            OP_MULT, OP_MULTU: begin
                o_res.hi_we  = 1'b1;
                o_res.lo_we  = 1'b1;
                o_res.hi_val = sext32({32'b0, mul_p[63:32]});
                o_res.lo_val = sext32({32'b0, mul_p[31:0]});
            end
            default:   o_res.bad_op = 1'b1;
        endcase

        // Register zero is never written; report no write at all in that case.
        if (we && (widx != '0)) begin
            o_res.gpr_we  = 1'b1;
            o_res.gpr_idx = widx;
            o_res.gpr_val = val;
        end else begin
            o_res.gpr_we  = 1'b0;
            o_res.gpr_idx = '0;
            o_res.gpr_val = '0;
        end
    end

endmodule

FILE: rtl/mips64_integer_execute_unit.sv
// Top level of the 64-bit integer execute unit: input stage, execute logic, result register.
// Instantiates m64ieu_regfile and m64ieu_alu; uses m64ieu_pkg.
//
// Usage:
//   The slave stream carries one decoded instruction per request: opcode, rs, rt, rd
//   and the raw 16-bit immediate. The master stream returns one result per request:
//   the general register write (enable, index, value), HI and LO after the instruction,
//   and a flag for an opcode with no implementation.
//   The result is valid on the master side once the result register is loaded:
//   the register file read is registered with the instruction in the input stage, and the
//   execute logic loads the result register when it is free or drains. Throughput is
//   one instruction per cycle while the receiver does not stall; an instruction may use
//   the register that the previous one writes, through forwarding in the register file.
//   Reset clears HI, LO and the written flags of all registers, so every register reads
//   zero until written; both stages come up empty.
//   When the receiver stalls, the result register holds its request, the input stage
//   fills, and s_axis_tready drops until the result is taken. State is updated only
//   when an instruction moves from the input stage into the result register.
module mips64_integer_execute_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // [5:0] req_type, [10:6] src_a, [15:11] src_b, [20:16] dest, [36:21] imm, rest zero
    input  logic [m64ieu_pkg::IN_DW-1:0]      s_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [0] write_enable, [5:1] write_index, [69:6] write_value, [133:70] hi_value,
    // [197:134] lo_value, [198] bad_opcode, [199] zero
    output logic [m64ieu_pkg::OUT_DW-1:0]     m_axis_tdata
);
    import m64ieu_pkg::*;

    logic               in_fire;
    logic               s1_adv;
    logic               r_s1_valid;
    logic [OP_W-1:0]    r_s1_op;
    logic [REG_AW-1:0]  r_s1_rt_idx;
    logic [REG_AW-1:0]  r_s1_rd_idx;
    logic [IMM_W-1:0]   r_s1_imm;
    logic [XLEN-1:0]    rs_val;
    logic [XLEN-1:0]    rt_val;
    logic [XLEN-1:0]    r_hi;
    logic [XLEN-1:0]    r_lo;
    logic [XLEN-1:0]    n_hi;
    logic [XLEN-1:0]    n_lo;
    t_exec_res          exec_res;
    logic               r_out_valid;
    logic               r_out_we;
    logic [REG_AW-1:0]  r_out_idx;
    logic [XLEN-1:0]    r_out_val;
    logic [XLEN-1:0]    r_out_hi;
    logic [XLEN-1:0]    r_out_lo;
    logic               r_out_bad;

    // Handshake: the input stage moves on whenever the result register is free or drains.
    assign s1_adv        = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // Register file, read at the accepting edge and written as an instruction retires.
    m64ieu_regfile u_regfile (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (in_fire),
        .i_rd_addr_a (s_axis_tdata[10:6]),
        .i_rd_addr_b (s_axis_tdata[15:11]),
        .i_wr_en     (s1_adv && exec_res.gpr_we),
        .i_wr_addr   (exec_res.gpr_idx),
        .i_wr_data   (exec_res.gpr_val),
        .o_rd_data_a (rs_val),
        .o_rd_data_b (rt_val)
    );

    // Input stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_fire) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Input stage payload.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_op     <= s_axis_tdata[5:0];
            r_s1_rt_idx <= s_axis_tdata[15:11];
            r_s1_rd_idx <= s_axis_tdata[20:16];
            r_s1_imm    <= s_axis_tdata[36:21];
        end
    end

    m64ieu_alu u_alu (
        .i_op     (r_s1_op),
        .i_rs     (rs_val),
        .i_rt     (rt_val),
        .i_rt_idx (r_s1_rt_idx),
        .i_rd_idx (r_s1_rd_idx),
        .i_imm    (r_s1_imm),
        .i_hi     (r_hi),
        .i_lo     (r_lo),
        .o_res    (exec_res)
    );

    // Next HI and LO as seen after this instruction.
    assign n_hi = exec_res.hi_we ? exec_res.hi_val : r_hi;
    assign n_lo = exec_res.lo_we ? exec_res.lo_val : r_lo;

    // HI/LO state and result valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hi        <= '0;
            r_lo        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_hi        <= n_hi;
                r_lo        <= n_lo;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_we  <= exec_res.gpr_we;
            r_out_idx <= exec_res.gpr_idx;
            r_out_val <= exec_res.gpr_val;
            r_out_hi  <= n_hi;
            r_out_lo  <= n_lo;
            r_out_bad <= exec_res.bad_op;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_bad, r_out_lo, r_out_hi, r_out_val, r_out_idx, r_out_we};

endmodule
